/* design/bre_pkg.sv */
// Shared constants, codes and helpers for the BFS reachability engine.
// No dependencies; imported by bfs_reachability_engine.
package bre_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VTX_W + 1;
  localparam int ROW_W        = MAX_VERTICES;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [VTX_W-1:0] vtx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    FN_WRITE_ROW = 2'd0,
    FN_REACH     = 2'd1,
    FN_CONNECT   = 2'd2,
    FN_UNUSED    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PICK,
    ST_EXPAND,
    ST_CHECK,
    ST_OUT
  } state_t;

  // lowest set bit of a row; zero when the row is empty
  function automatic vtx_t first_set(input row_t v);
    vtx_t idx;
    idx = '0;
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if (v[k]) idx = vtx_t'(k);
    end
    return idx;
  endfunction

  // mask of vertices below n
  function automatic row_t low_mask(input cnt_t n);
    row_t m;
    if (n >= cnt_t'(MAX_VERTICES)) m = '1;
    else m = (row_t'(1) << n) - row_t'(1);
    return m;
  endfunction

endpackage

/* design/bfs_reachability_engine.sv */
// BFS reachability engine: adjacency store, search sequencer and result register.
// Depends on bre_pkg.
//
// Usage:
//  Input beats carry a command in in_tuser (0 write row, 1 reachability, 2 connectivity)
//  and its operands in in_tdata. Each input beat yields exactly one result beat on the
//  out_ channel; out_tdata[0] is the answer (0 for row writes and unused commands).
//  cfg_wr_en/cfg_wr_data set the number of vertices in use (reset 64); write it only
//  while no command is in flight.
//  A row write or trivial query goes straight to the output state and then into the
//  output register. A search expands one visited vertex at a time: it picks the vertex,
//  then reads its row through the single row-read port of the adjacency memory.
//  Connectivity runs one search per vertex i below n-1. One command is worked on at a
//  time; in_tready is high only while the sequencer is idle.
//  Reset (rst_n low, synchronous) clears all adjacency rows through per-row valid
//  bits at once, so the block is ready in the first cycle after reset.
//  A stalled receiver holds the result in the output register; the next command
//  may be accepted meanwhile, but its result waits until that register is free.
module bfs_reachability_engine
  import bre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] row_index, [69:6] row_bits, [75:70] start_vertex, [81:76] target_vertex
  input  logic [87:0] in_tdata,
  // [1:0] func
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] answer
  output logic [7:0]  out_tdata,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  state_t state_r, state_nxt;
  func_t  func_r, func_nxt;
  vtx_t   src_r, src_nxt;
  vtx_t   tgt_r, tgt_nxt;
  row_t   visited_r, visited_nxt;
  row_t   pending_r, pending_nxt;
  logic   ans_r, ans_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_ans_r, out_ans_nxt;
  cnt_t   vcount_r;
  row_t   row_vld_r;

  row_t   adj_mem [MAX_VERTICES];
  row_t   rd_row_r;
  logic   rd_vld_r;

  vtx_t   in_row;
  row_t   in_bits;
  vtx_t   in_start;
  vtx_t   in_target;
  func_t  in_func;
  logic   in_fire;
  logic   wr_en;

  cnt_t   n_eff;
  row_t   present;
  vtx_t   pick_idx;
  row_t   nbrs;
  row_t   fresh;
  row_t   hi_mask;

  assign in_row    = in_tdata[5:0];
  assign in_bits   = in_tdata[69:6];
  assign in_start  = in_tdata[75:70];
  assign in_target = in_tdata[81:76];
  assign in_func   = func_t'(in_tuser);

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign wr_en      = in_fire && (in_func == FN_WRITE_ROW);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_ans_r};

  assign n_eff    = (vcount_r > cnt_t'(MAX_VERTICES)) ? cnt_t'(MAX_VERTICES) : vcount_r;
  assign present  = low_mask(n_eff);
  assign pick_idx = first_set(pending_r);
  assign nbrs     = (rd_vld_r ? rd_row_r : '0) & present;
  assign fresh    = nbrs & ~visited_r;
  // vertices above the current source
  assign hi_mask  = present & ('1 << ({1'b0, src_r} + cnt_t'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      vcount_r     <= cnt_t'(MAX_VERTICES);
      row_vld_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) vcount_r <= cfg_wr_data;
      if (wr_en) row_vld_r[in_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    src_r     <= src_nxt;
    tgt_r     <= tgt_nxt;
    visited_r <= visited_nxt;
    pending_r <= pending_nxt;
    ans_r     <= ans_nxt;
    out_ans_r <= out_ans_nxt;
  end

  // adjacency store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) adj_mem[in_row] <= in_bits;
    if (state_r == ST_PICK) begin
      rd_row_r <= adj_mem[pick_idx];
      rd_vld_r <= row_vld_r[pick_idx];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    src_nxt        = src_r;
    tgt_nxt        = tgt_r;
    visited_nxt    = visited_r;
    pending_nxt    = pending_r;
    ans_nxt        = ans_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_ans_nxt    = out_ans_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt  = in_func;
          src_nxt   = in_start;
          tgt_nxt   = in_target;
          ans_nxt   = 1'b0;
          state_nxt = ST_OUT;
          case (in_func)
            FN_REACH: begin
              if (({1'b0, in_start} >= n_eff) || ({1'b0, in_target} >= n_eff)) begin
                ans_nxt = 1'b0;
              end else if (in_start == in_target) begin
                ans_nxt = 1'b1;
              end else begin
                state_nxt = ST_LOAD;
              end
            end
            FN_CONNECT: begin
              src_nxt = '0;
              if (n_eff <= cnt_t'(1)) ans_nxt = 1'b1;
              else state_nxt = ST_LOAD;
            end
            default: ans_nxt = 1'b0;
          endcase
        end
      end
      ST_LOAD: begin
        visited_nxt = row_t'(1) << src_r;
        pending_nxt = row_t'(1) << src_r;
        state_nxt   = ST_PICK;
      end
      ST_PICK: begin
        if (pending_r == '0) begin
          state_nxt = ST_CHECK;
        end else begin
          pending_nxt[pick_idx] = 1'b0;
          state_nxt = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        visited_nxt = visited_r | fresh;
        pending_nxt = pending_r | fresh;
        state_nxt   = ST_PICK;
      end
      ST_CHECK: begin
        state_nxt = ST_OUT;
        if (func_r == FN_REACH) begin
          ans_nxt = visited_r[tgt_r];
        end else if ((visited_r & hi_mask) != hi_mask) begin
          ans_nxt = 1'b0;
        end else if (({1'b0, src_r} + cnt_t'(2)) == n_eff) begin
          ans_nxt = 1'b1;
        end else begin
          src_nxt   = src_r + vtx_t'(1);
          state_nxt = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_ans_nxt    = ans_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // every vertex waiting for expansion has been marked
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK || state_r == ST_EXPAND) |-> ((pending_r & ~visited_r) == '0))
    else $error("pending vertex not marked visited");

  // marks only grow during a search
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXPAND) |=> ((visited_r & $past(visited_r)) == $past(visited_r)))
    else $error("visited marks lost during expansion");

  // a pick with work left always moves on to expansion
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK && pending_r != '0) |=> (state_r == ST_EXPAND))
    else $error("row read not followed by expansion");

  // a result is only loaded from the output state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_OUT))
    else $error("unexpected result load");

  // the sequencer waits in the output state while a held result stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready && state_r == ST_OUT) |=> (state_r == ST_OUT))
    else $error("result dropped while output stalled");

endmodule
